/* hw/rtl/ile_pkg.sv */
// ile_pkg: shared opcodes, status codes, sizes and structs of the indexed list engine
// no dependencies; used by every module of the block

package ile_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 5;

  typedef enum logic [3:0] {
    OP_INSERT_AT    = 4'd0,
    OP_INSERT_FRONT = 4'd1,
    OP_INSERT_END   = 4'd2,
    OP_REMOVE_AT    = 4'd3,
    OP_REMOVE_FRONT = 4'd4,
    OP_REMOVE_END   = 4'd5,
    OP_GET          = 4'd6,
    OP_FIND_FIRST   = 4'd7,
    OP_FIND_LAST    = 4'd8,
    OP_FIND_MAX     = 4'd9,
    OP_CLEAR        = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EV,
    S_WR,
    S_DONE
  } state_t;

  // memory port strobes from the sequencer
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // one finished result
  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic [POS_W-1:0]  found_position;
    logic [1:0]        status;
    logic [POS_W-1:0]  entry_count;
  } res_t;

  localparam logic [POS_W-1:0] POS_NONE = '1;

endpackage

/* hw/rtl/ile_mem.sv */
// ile_mem: entry storage, one write and one registered read port
// depends on ile_pkg

module ile_mem import ile_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  mem_ctl_t          ctl,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/ile_ctrl.sv */
// ile_ctrl: sequencer that walks the entry memory for each request
// depends on ile_pkg; drives ile_mem

module ile_ctrl import ile_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [3:0]        req_opcode,
  input  logic [DATA_W-1:0] req_value,
  input  logic [POS_W-1:0]  req_position,
  input  logic              res_blocked,
  output logic              res_done,
  output res_t              res,
  output mem_ctl_t          mctl,
  output logic [AW-1:0]     waddr,
  output logic [DATA_W-1:0] wdata,
  output logic [AW-1:0]     raddr,
  input  logic [DATA_W-1:0] rdata
);

  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  state_t            state_r, state_nxt;
  logic [3:0]        op_r, op_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [AW-1:0]     p_r, p_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rd_r, rd_nxt;
  logic [DATA_W-1:0] best_r, best_nxt;
  logic [POS_W-1:0]  found_r, found_nxt;
  logic [1:0]        st_r, st_nxt;
  logic              hit_r, hit_nxt;

  logic [CMPW-1:0] pos_ext, cnt_ext;
  logic            full, empty, last, go_scan, go_wr, ev_done, ev_wr;

  assign pos_ext = CMPW'(req_position);
  assign cnt_ext = CMPW'(cnt_r);
  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign last    = (idx_r == AW'(cnt_r - CW'(1)));

  // decode of the request at acceptance
  always_comb begin
    go_scan = 1'b0;
    go_wr   = 1'b0;
    case (op_t'(req_opcode))
      OP_INSERT_AT: begin
        if (pos_ext <= cnt_ext && !full) begin
          go_scan = (pos_ext < cnt_ext);
          go_wr   = (pos_ext == cnt_ext);
        end
      end
      OP_INSERT_FRONT: begin
        go_scan = !full && !empty;
        go_wr   = !full && empty;
      end
      OP_INSERT_END:   go_wr   = !full;
      OP_REMOVE_AT:    go_scan = (pos_ext < cnt_ext);
      OP_REMOVE_FRONT, OP_REMOVE_END, OP_FIND_FIRST, OP_FIND_LAST, OP_FIND_MAX:
        go_scan = !empty;
      OP_GET:          go_scan = (pos_ext < cnt_ext);
      default: ;
    endcase
  end

  // what the evaluate step does with the data just read
  always_comb begin
    ev_done = 1'b0;
    case (op_t'(op_r))
      OP_INSERT_AT, OP_INSERT_FRONT, OP_INSERT_END: ev_done = 1'b0;
      OP_GET:  ev_done = 1'b1;
      default: ev_done = last;
    endcase
  end

  assign ev_wr = (op_r == OP_INSERT_AT) || (op_r == OP_INSERT_FRONT) ||
                 (op_r == OP_INSERT_END);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          state_nxt = go_scan ? S_RD : (go_wr ? S_WR : S_DONE);
        end
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        if (ev_wr) begin
          state_nxt = (idx_r == p_r) ? S_WR : S_RD;
        end else begin
          state_nxt = ev_done ? S_DONE : S_RD;
        end
      end
      S_WR:   state_nxt = S_DONE;
      S_DONE: if (!res_blocked) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory strobes
  always_comb begin
    op_nxt    = op_r;
    val_nxt   = val_r;
    p_nxt     = p_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    rd_nxt    = rd_r;
    best_nxt  = best_r;
    found_nxt = found_r;
    st_nxt    = st_r;
    hit_nxt   = hit_r;
    mctl      = '0;
    waddr     = idx_r;
    wdata     = rdata;
    raddr     = idx_r;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt    = req_opcode;
          val_nxt   = req_value;
          rd_nxt    = '0;
          found_nxt = POS_NONE;
          st_nxt    = ST_OK;
          hit_nxt   = 1'b0;
          p_nxt     = AW'(req_position);
          idx_nxt   = '0;
          case (op_t'(req_opcode))
            OP_INSERT_AT: begin
              if (pos_ext > cnt_ext) st_nxt = ST_RANGE;
              else if (full)         st_nxt = ST_FULL;
              idx_nxt = AW'(cnt_r - CW'(1));
            end
            OP_INSERT_FRONT: begin
              if (full) st_nxt = ST_FULL;
              p_nxt   = '0;
              idx_nxt = AW'(cnt_r - CW'(1));
            end
            OP_INSERT_END: begin
              if (full) st_nxt = ST_FULL;
              p_nxt = AW'(cnt_r);
            end
            OP_REMOVE_AT, OP_GET: begin
              if (pos_ext >= cnt_ext) st_nxt = ST_RANGE;
              idx_nxt = AW'(req_position);
            end
            OP_REMOVE_FRONT: begin
              if (empty) st_nxt = ST_RANGE;
              p_nxt = '0;
            end
            OP_REMOVE_END: begin
              if (empty) st_nxt = ST_RANGE;
              p_nxt   = AW'(cnt_r - CW'(1));
              idx_nxt = AW'(cnt_r - CW'(1));
            end
            OP_FIND_MAX: if (empty) st_nxt = ST_RANGE;
            OP_CLEAR:    cnt_nxt = '0;
            default: ;
          endcase
        end
      end
      S_RD: mctl.re = 1'b1;
      S_EV: begin
        case (op_t'(op_r))
          OP_INSERT_AT, OP_INSERT_FRONT, OP_INSERT_END: begin
            // move entry up one place
            mctl.we = 1'b1;
            waddr   = idx_r + AW'(1);
            if (idx_r != p_r) idx_nxt = idx_r - AW'(1);
          end
          OP_REMOVE_AT, OP_REMOVE_FRONT, OP_REMOVE_END: begin
            if (idx_r == p_r) begin
              rd_nxt = rdata;
            end else begin
              mctl.we = 1'b1;
              waddr   = idx_r - AW'(1);
            end
            if (last) cnt_nxt = cnt_r - CW'(1);
          end
          OP_GET: rd_nxt = rdata;
          OP_FIND_FIRST: begin
            if (rdata == val_r && !hit_r) begin
              found_nxt = POS_W'(idx_r);
              hit_nxt   = 1'b1;
            end
          end
          OP_FIND_LAST: if (rdata == val_r) found_nxt = POS_W'(idx_r);
          OP_FIND_MAX: begin
            if (idx_r == '0 || $signed(rdata) > $signed(best_r)) begin
              best_nxt  = rdata;
              found_nxt = POS_W'(idx_r);
            end
          end
          default: ;
        endcase
        if (!ev_wr && !last) idx_nxt = idx_r + AW'(1);
      end
      S_WR: begin
        mctl.we = 1'b1;
        waddr   = p_r;
        wdata   = val_r;
        cnt_nxt = cnt_r + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    val_r   <= val_nxt;
    p_r     <= p_nxt;
    idx_r   <= idx_nxt;
    rd_r    <= rd_nxt;
    best_r  <= best_nxt;
    found_r <= found_nxt;
    st_r    <= st_nxt;
    hit_r   <= hit_nxt;
  end

  assign req_ready          = (state_r == S_IDLE);
  assign res_done           = (state_r == S_DONE) && !res_blocked;
  assign res.read_value     = rd_r;
  assign res.found_position = found_r;
  assign res.status         = st_r;
  assign res.entry_count    = POS_W'(cnt_r);

endmodule

/* hw/rtl/indexed_list_engine.sv */
// indexed_list_engine: top level of the ordered list engine
// depends on ile_pkg, ile_ctrl and ile_mem
//
// usage
//   input channel in_valid/in_stall carries one request transaction: opcode,
//   value and position. a transaction is taken when in_valid is high and
//   in_stall low. in_stall is high while a request is in work, so no new
//   one is taken until the last is done; in_stall drops as out_valid rises
//   result channel out_valid/out_stall returns one transaction per request:
//   read_value, found_position, status and entry_count.
// sequencing
//   clear, rejected requests and unknown opcodes touch no entry; get
//   reads one entry; insert_end writes one entry and moves none
//   insert at position p moves the entries from the end down to p
//   (one read and one write per moved entry through the single memory port
//   pair); remove at p moves those after p; find ops read every entry
// reset
//   rst_n low clears the count and the sequencer; entry contents are kept
//   but unused until written again
// backpressure
//   a finished result sits in the output register while out_stall is high;
//   a new request may be taken meanwhile and waits at its end for the
//   register to free

module indexed_list_engine import ile_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        in_opcode,
  input  logic [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]  in_position,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_read_value,
  output logic [POS_W-1:0]  out_found_position,
  output logic [1:0]        out_status,
  output logic [POS_W-1:0]  out_entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mem_ctl_t          mctl;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;
  logic              req_ready, res_done, res_blocked;
  res_t              res;

  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  // output register still full and not taken this cycle
  assign res_blocked = out_valid_r && out_stall;

  ile_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_valid),
    .req_ready    (req_ready),
    .req_opcode   (in_opcode),
    .req_value    (in_value),
    .req_position (in_position),
    .res_blocked  (res_blocked),
    .res_done     (res_done),
    .res          (res),
    .mctl         (mctl),
    .waddr        (waddr),
    .wdata        (wdata),
    .raddr        (raddr),
    .rdata        (rdata)
  );

  ile_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .ctl   (mctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // result holds until taken
  assign out_valid_nxt = res_done || res_blocked;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_done) begin
      out_r <= res;
    end
  end

  assign in_stall           = !req_ready;
  assign out_valid          = out_valid_r;
  assign out_read_value     = out_r.read_value;
  assign out_found_position = out_r.found_position;
  assign out_status         = out_r.status;
  assign out_entry_count    = out_r.entry_count;

endmodule

/* hw/rtl/ile_checker.sv */
// ile_checker: port level assertions for indexed_list_engine, bound to the top
// depends on ile_pkg and indexed_list_engine

module ile_checker import ile_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [DATA_W-1:0] out_read_value,
  input logic [1:0]        out_status,
  input logic [POS_W-1:0]  out_entry_count
);

  // a stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value))
    else $error("stalled result changed");

  // one request in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status code");

  // full status only comes with a full list
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == POS_W'(DEPTH))
    else $error("full status with room left");

endmodule

bind indexed_list_engine ile_checker #(.DEPTH(DEPTH)) u_ile_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_read_value  (out_read_value),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);

/* sim/indexed_list_engine_tb.sv */
// indexed_list_engine_tb: self-checking testbench of the indexed list engine
// depends on ile_pkg and indexed_list_engine; a scoreboard class predicts each result
`timescale 1ns / 100ps

module indexed_list_engine_tb;
  import ile_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic [POS_W-1:0]  found_position;
    logic [1:0]        status;
    logic [POS_W-1:0]  entry_count;
  } list_result_t;

  // list model plus queue of pending results
  class list_scoreboard;
    logic [DATA_W-1:0] slots[LIST_DEPTH];
    int                used;
    list_result_t      pending[$];
    int                errors;

    function new();
      used = 0;
      errors = 0;
    endfunction

    function void note_request(logic [3:0] op, logic [DATA_W-1:0] val, logic [POS_W-1:0] pos);
      list_result_t r;
      int ins_pos;
      int rem_pos;
      int best;
      r.read_value = '0;
      r.found_position = POS_NONE;
      r.status = ST_OK;
      ins_pos = -1;
      rem_pos = -1;
      case (op)
        OP_INSERT_AT: begin
          if (pos > used) r.status = ST_RANGE;
          else ins_pos = pos;
        end
        OP_INSERT_FRONT: ins_pos = 0;
        OP_INSERT_END: ins_pos = used;
        OP_REMOVE_AT: begin
          if (pos >= used) r.status = ST_RANGE;
          else rem_pos = pos;
        end
        OP_REMOVE_FRONT: begin
          if (used == 0) r.status = ST_RANGE;
          else rem_pos = 0;
        end
        OP_REMOVE_END: begin
          if (used == 0) r.status = ST_RANGE;
          else rem_pos = used - 1;
        end
        OP_GET: begin
          if (pos >= used) r.status = ST_RANGE;
          else r.read_value = slots[pos];
        end
        OP_FIND_FIRST: begin
          for (int i = used - 1; i >= 0; i--)
            if (slots[i] == val) r.found_position = POS_W'(i);
        end
        OP_FIND_LAST: begin
          for (int i = 0; i < used; i++)
            if (slots[i] == val) r.found_position = POS_W'(i);
        end
        OP_FIND_MAX: begin
          if (used == 0) r.status = ST_RANGE;
          else begin
            best = 0;
            for (int i = 1; i < used; i++)
              if ($signed(slots[i]) > $signed(slots[best])) best = i;
            r.found_position = POS_W'(best);
          end
        end
        OP_CLEAR: used = 0;
        default: ;
      endcase
      if (ins_pos >= 0) begin
        if (used >= LIST_DEPTH) r.status = ST_FULL;
        else begin
          for (int i = used; i > ins_pos; i--) slots[i] = slots[i-1];
          slots[ins_pos] = val;
          used++;
        end
      end
      if (rem_pos >= 0) begin
        r.read_value = slots[rem_pos];
        for (int i = rem_pos; i + 1 < used; i++) slots[i] = slots[i+1];
        used--;
      end
      r.entry_count = POS_W'(used);
      pending.push_back(r);
    endfunction

    function void check_result(list_result_t got);
      list_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.read_value !== exp_r.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, exp_r.read_value, got.read_value);
        errors++;
      end
      if (got.found_position !== exp_r.found_position) begin
        $display("%0t: found_position expected %h actual %h", $time,
                 exp_r.found_position, got.found_position);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %h actual %h", $time, exp_r.status, got.status);
        errors++;
      end
      if (got.entry_count !== exp_r.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time,
                 exp_r.entry_count, got.entry_count);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [3:0]        in_opcode;
  logic [DATA_W-1:0] in_value;
  logic [POS_W-1:0]  in_position;
  logic              out_valid;
  logic              out_stall;
  logic [DATA_W-1:0] out_read_value;
  logic [POS_W-1:0]  out_found_position;
  logic [1:0]        out_status;
  logic [POS_W-1:0]  out_entry_count;

  list_scoreboard sb;
  bit             calm;       // no idling on either side while set

  indexed_list_engine #(.DEPTH(LIST_DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_value(in_value), .in_position(in_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_value(out_read_value), .out_found_position(out_found_position),
    .out_status(out_status), .out_entry_count(out_entry_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // send one request transaction; driven at the falling edge, held until taken
  // in_valid stays high into the next transaction unless an idle gap is drawn
  task automatic send_request(logic [3:0] op, logic [DATA_W-1:0] val, logic [POS_W-1:0] pos);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 10) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_value <= val;
    in_position <= pos;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_request(op, val, pos);
    @(negedge clk);
  endtask

  // values drawn from a small pool so that searches hit, with extremes mixed in
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $urandom_range(7) - 3;
    endcase
  endfunction

  // opcode weights tilt insert vs remove so the list swings between empty and full
  function automatic logic [3:0] pick_op(bit grow);
    int r;
    r = $urandom_range(99);
    if (r < 3) return 4'(11 + $urandom_range(4));
    if (r < 5) return OP_CLEAR;
    if (r < 40) return grow ? op_t'($urandom_range(2)) : op_t'(3 + $urandom_range(2));
    if (r < 55) return grow ? op_t'(3 + $urandom_range(2)) : op_t'($urandom_range(2));
    return op_t'(6 + $urandom_range(3));
  endfunction

  // result side: random stall, checked at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_read_value, out_found_position, out_status, out_entry_count});
  end

  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 10);
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    bit grow;
    sb = new();
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_CLEAR;
    in_value = '0;
    in_position = '0;
    out_stall = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty-list errors, fill past full, range errors, searches, drain
    send_request(OP_REMOVE_FRONT, 0, 0);
    send_request(OP_REMOVE_END, 0, 0);
    send_request(OP_FIND_MAX, 0, 0);
    send_request(OP_FIND_LAST, 5, 0);
    send_request(OP_FIND_FIRST, 5, 0);
    send_request(OP_INSERT_AT, 1, 1);
    send_request(OP_INSERT_AT, 32'h8000_0000, 0);
    send_request(OP_INSERT_FRONT, 32'h7fff_ffff, 0);
    send_request(OP_INSERT_END, 32'hffff_ffff, 0);
    for (int i = 0; i < 14; i++) send_request(OP_INSERT_AT, DATA_W'(i), POS_W'(i % 4));
    send_request(OP_INSERT_AT, 9, 17);
    send_request(OP_INSERT_AT, 9, 31);
    send_request(OP_GET, 0, 15);
    send_request(OP_GET, 0, 16);
    send_request(OP_REMOVE_AT, 0, 16);
    send_request(OP_FIND_MAX, 0, 0);
    send_request(OP_FIND_FIRST, 2, 0);
    send_request(OP_FIND_LAST, 2, 0);
    send_request(OP_REMOVE_AT, 0, 15);
    send_request(OP_REMOVE_AT, 0, 0);
    send_request(4'd15, 32'hffff_ffff, 31);
    send_request(OP_CLEAR, 0, 0);

    // random: phases of growth and shrink, with a calm stretch in the middle
    grow = 1'b1;
    for (int n = 0; n < 950; n++) begin
      if (n % 60 == 0) grow = !grow;
      calm = (n >= 400 && n < 550);
      send_request(pick_op(grow), pick_value(),
                   POS_W'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(16)));
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
